// ===== hdl/hpt_pkg.sv =====
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int REG_W         = 64;
	localparam int ADDR_W        = 6;
	localparam int ROW_W         = 64;
	localparam int DIV_STEPS     = 64;

	typedef struct packed {
		logic              div;
		logic              nd_sat;
		logic [2:0]        neg;
		logic [2:0][31:0]  nd_val;
	} hpt_ctl_t;

endpackage

// ===== hdl/homogeneous_point_transform.sv =====
// Pipelined 4x4 homogeneous vertex transform with a bit-per-stage divider.
// Throughput: one transaction per cycle while the pipeline is not held by out_stall.
// The 64 restoring divide stages set the depth of the pipeline.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_transform #(
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic signed [31:0]          vx,
	input  logic signed [31:0]          vy,
	input  logic signed [31:0]          vz,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          out_x,
	output logic signed [31:0]          out_y,
	output logic signed [31:0]          out_z,
	output logic                        divided,
	output logic                        saturated,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [hpt_pkg::REG_W-1:0]   pwdata,
	output logic [hpt_pkg::REG_W-1:0]   prdata,
	output logic                        pready
);

	localparam int N = hpt_pkg::DIV_STEPS;
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	logic [hpt_pkg::REG_W-1:0] mat_q [hpt_pkg::NUM_REGS];
	logic [2:0] widx;
	logic adv;

	logic              vld_s1, vld_s2, vld_s3;
	logic              op_s1, op_s2, op_s3;
	logic signed [31:0] v_s1 [3];
	logic signed [63:0] prod_s2 [4][3];
	logic signed [63:0] trn_s2 [4];
	logic signed [63:0] row_s3 [4];

	logic              vld_d_s [N+1];
	logic [63:0]       rem_d_s [N+1][3];
	logic [63:0]       dvd_d_s [N+1][3];
	logic [63:0]       quo_d_s [N+1][3];
	logic [63:0]       den_d_s [N+1];
	hpt_pkg::hpt_ctl_t ctl_d_s [N+1];

	logic signed [31:0] res_c [3];
	logic               dsat_c;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;
	assign pready   = 1'b1;
	assign widx     = paddr[hpt_pkg::ADDR_W-1:3];
	assign prdata   = mat_q[widx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hpt_pkg::NUM_REGS; i++) mat_q[i] <= '0;
			mat_q[0] <= ONE;
			mat_q[2] <= ONE << 32;
			mat_q[5] <= ONE;
			mat_q[7] <= ONE << 32;
		end else if (psel && penable && pwrite) begin
			mat_q[widx] <= pwdata;
		end
	end

	function automatic logic signed [63:0] elem(input logic [63:0] r);
		return 64'($signed(r[31:0]));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_d_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_d_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [65:0] acc;
		logic signed [65:0] sh;
		logic signed [63:0] rw;
		logic signed [63:0] rv;
		logic [63:0] mr;
		logic [63:0] mw;
		logic dv;
		logic ns;
		if (adv) begin
			op_s1   <= op;
			v_s1[0] <= vx;
			v_s1[1] <= vy;
			v_s1[2] <= vz;

			op_s2 <= op_s1;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r][c] <= elem((c == 2) ? mat_q[2*r+1] :
						((c == 1) ? (mat_q[2*r] >> 32) : mat_q[2*r])) * 64'(v_s1[c]);
				end
				trn_s2[r] <= op_s1 ? 64'sd0 : (elem(mat_q[2*r+1] >> 32) <<< FRAC_BITS);
			end

			op_s3 <= op_s2;
			for (int r = 0; r < 4; r++) begin
				acc = 66'(prod_s2[r][0]) + 66'(prod_s2[r][1]) + 66'(prod_s2[r][2])
					+ 66'(trn_s2[r]);
				sh = acc >>> FRAC_BITS;
				row_s3[r] <= sh[63:0];
			end

			rw = row_s3[3];
			dv = !op_s3 && (rw != 64'sd0) && (rw != $signed(ONE));
			mw = rw[63] ? (64'd0 - 64'(rw)) : 64'(rw);
			ns = 1'b0;
			den_d_s[0] <= mw;
			for (int i = 0; i < 3; i++) begin
				rv = row_s3[i];
				mr = rv[63] ? (64'd0 - 64'(rv)) : 64'(rv);
				rem_d_s[0][i] <= '0;
				quo_d_s[0][i] <= '0;
				dvd_d_s[0][i] <= mr << FRAC_BITS;
				ctl_d_s[0].neg[i] <= rv[63] ^ rw[63];
				if (rv > 64'sh7FFFFFFF) begin
					ctl_d_s[0].nd_val[i] <= 32'h7FFFFFFF;
					ns = 1'b1;
				end else if (rv < -64'sh80000000) begin
					ctl_d_s[0].nd_val[i] <= 32'h80000000;
					ns = 1'b1;
				end else begin
					ctl_d_s[0].nd_val[i] <= rv[31:0];
				end
			end
			ctl_d_s[0].div    <= dv;
			ctl_d_s[0].nd_sat <= ns;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d_s[k] <= 1'b0;
			end else if (adv) begin
				vld_d_s[k] <= vld_d_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			logic [64:0] t;
			logic ge;
			if (adv) begin
				den_d_s[k] <= den_d_s[k-1];
				ctl_d_s[k] <= ctl_d_s[k-1];
				for (int i = 0; i < 3; i++) begin
					t  = {rem_d_s[k-1][i], dvd_d_s[k-1][i][63]};
					ge = t >= {1'b0, den_d_s[k-1]};
					rem_d_s[k][i] <= ge ? 64'(t - {1'b0, den_d_s[k-1]}) : t[63:0];
					dvd_d_s[k][i] <= dvd_d_s[k-1][i] << 1;
					quo_d_s[k][i] <= {quo_d_s[k-1][i][62:0], ge};
				end
			end
		end
	end

	always_comb begin
		dsat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (ctl_d_s[N].neg[i]) begin
				if (quo_d_s[N][i] > 64'h80000000) begin
					res_c[i] = 32'sh80000000;
					dsat_c = 1'b1;
				end else begin
					res_c[i] = $signed(32'd0 - quo_d_s[N][i][31:0]);
				end
			end else if (quo_d_s[N][i] > 64'h7FFFFFFF) begin
				res_c[i] = 32'sh7FFFFFFF;
				dsat_c = 1'b1;
			end else begin
				res_c[i] = $signed(quo_d_s[N][i][31:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_d_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x     <= ctl_d_s[N].div ? res_c[0] : $signed(ctl_d_s[N].nd_val[0]);
			out_y     <= ctl_d_s[N].div ? res_c[1] : $signed(ctl_d_s[N].nd_val[1]);
			out_z     <= ctl_d_s[N].div ? res_c[2] : $signed(ctl_d_s[N].nd_val[2]);
			divided   <= ctl_d_s[N].div;
			saturated <= ctl_d_s[N].div ? dsat_c : ctl_d_s[N].nd_sat;
		end
	end

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid) else $error("input stalled with no pending result");
	a_hold_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_d_s[N]) && $stable(vld_s1)) else $error("pipeline moved under stall");
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_d_s[N] |=> out_valid) else $error("divider result lost");
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1) else $error("accepted transaction dropped");

endmodule
